>>> rtl/htfd_pkg.sv
`default_nettype none
package htfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned TEMP_W   = 17;
  localparam int unsigned HUM_W    = 15;
  localparam int unsigned TTERM_W  = 15;
  localparam int unsigned NQ_W     = 31;
  localparam int unsigned SUM_W    = 33;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 17'sd10240;
  localparam logic signed [TEMP_W-1:0] TEMP_REF    = 17'sd6400;
  localparam logic [WORD_W-1:0]        RAW_FULL    = 16'd65535;
  localparam logic signed [SUM_W-1:0]  HUM_BASE    = 33'sd7680;
  localparam logic signed [SUM_W-1:0]  HUM_FULL    = 33'sd25600;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_ENABLE = 2'd2;

  // Divider working set: partial remainder, dividend/quotient shift word, divisor
  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [NQ_W-1:0]   nq;
    logic [WORD_W-1:0] den;
  } htfd_div_t;

  // Per-item side information carried alongside the divider
  typedef struct packed {
    logic                      crc_err;
    logic signed [TEMP_W-1:0]  temp;
    logic signed [TTERM_W-1:0] tterm;
    logic                      cal;
    logic                      neg;
  } htfd_side_t;

  function automatic logic [BYTE_W-1:0] pair_crc(input logic [BYTE_W-1:0] first,
                                                 input logic [BYTE_W-1:0] second);
    logic [BYTE_W-1:0] acc;
    acc = CRC_INIT ^ first;
    for (int b = 0; b < BYTE_W; b++) begin
      acc = acc[BYTE_W-1] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
    end
    acc = acc ^ second;
    for (int b = 0; b < BYTE_W; b++) begin
      acc = acc[BYTE_W-1] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

>>> rtl/humidity_temp_frame_decoder_core.sv
// Pipeline: the front end, the 31-step restoring divider (one quotient bit per
// stage) and the output stage. Throughput: one frame per cycle while the
// result side does not stall; a stall holds only the stages that are full,
// so bubbles close up and input is still taken.
// Reset (rst, synchronous, active high) empties the pipeline and clears the
// calibration registers to zero.
`default_nettype none
module humidity_temp_frame_decoder_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [htfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [htfd_pkg::WORD_W-1:0]         cfg_data,
  input  wire logic                                frame_valid,
  output logic                                     frame_stall,
  input  wire logic [htfd_pkg::BYTE_W-1:0]         temp_high,
  input  wire logic [htfd_pkg::BYTE_W-1:0]         temp_low,
  input  wire logic [htfd_pkg::BYTE_W-1:0]         temp_check,
  input  wire logic [htfd_pkg::BYTE_W-1:0]         hum_high,
  input  wire logic [htfd_pkg::BYTE_W-1:0]         hum_low,
  input  wire logic [htfd_pkg::BYTE_W-1:0]         hum_check,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic                                     status,
  output logic signed [htfd_pkg::TEMP_W-1:0]       temperature_q8,
  output logic [htfd_pkg::HUM_W-1:0]               humidity_q8,
  output logic                                     cal_applied
);

  localparam int unsigned NDIV = htfd_pkg::NQ_W;
  localparam int unsigned LAST = NDIV + 1;

  logic [htfd_pkg::WORD_W-1:0] cal_high_point, cal_low_point;
  logic                        calibration_enable;

  // Stage 0 is the front end, stages 1..NDIV the divider, stage LAST the output
  logic [LAST:0]          v;
  logic [LAST:0]          en;
  htfd_pkg::htfd_div_t    dv [NDIV+1];
  htfd_pkg::htfd_side_t   sd [NDIV+1];

  // Configuration writes: an index beyond the list falls through untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_high_point     <= '0;
      cal_low_point      <= '0;
      calibration_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        htfd_pkg::REG_CAL_HIGH:   cal_high_point     <= cfg_data;
        htfd_pkg::REG_CAL_LOW:    cal_low_point      <= cfg_data;
        htfd_pkg::REG_CAL_ENABLE: calibration_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on this cycle
  assign en[LAST] = !v[LAST] || !result_stall;
  genvar k;
  generate
    for (k = 0; k < LAST; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate

  assign frame_stall = !en[0];

  htfd_front u_front (
    .clk                (clk),
    .rst                (rst),
    .adv                (en[0]),
    .v_in               (frame_valid),
    .temp_high          (temp_high),
    .temp_low           (temp_low),
    .temp_check         (temp_check),
    .hum_high           (hum_high),
    .hum_low            (hum_low),
    .hum_check          (hum_check),
    .cal_high_point     (cal_high_point),
    .cal_low_point      (cal_low_point),
    .calibration_enable (calibration_enable),
    .v_out              (v[0]),
    .div_out            (dv[0]),
    .side_out           (sd[0])
  );

  generate
    for (k = 1; k <= NDIV; k++) begin : g_div
      htfd_div_stage u_stage (
        .clk      (clk),
        .rst      (rst),
        .adv      (en[k]),
        .v_in     (v[k-1]),
        .div_in   (dv[k-1]),
        .side_in  (sd[k-1]),
        .v_out    (v[k]),
        .div_out  (dv[k]),
        .side_out (sd[k])
      );
    end
  endgenerate

  htfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .adv            (en[LAST]),
    .v_in           (v[NDIV]),
    .quot           (dv[NDIV].nq),
    .side_in        (sd[NDIV]),
    .v_out          (v[LAST]),
    .status         (status),
    .temperature_q8 (temperature_q8),
    .humidity_q8    (humidity_q8),
    .cal_applied    (cal_applied)
  );

  assign result_valid = v[LAST];

endmodule
`default_nettype wire

>>> rtl/htfd_front.sv
`default_nettype none
module htfd_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              adv,
  input  wire logic                              v_in,
  input  wire logic [htfd_pkg::BYTE_W-1:0]       temp_high,
  input  wire logic [htfd_pkg::BYTE_W-1:0]       temp_low,
  input  wire logic [htfd_pkg::BYTE_W-1:0]       temp_check,
  input  wire logic [htfd_pkg::BYTE_W-1:0]       hum_high,
  input  wire logic [htfd_pkg::BYTE_W-1:0]       hum_low,
  input  wire logic [htfd_pkg::BYTE_W-1:0]       hum_check,
  input  wire logic [htfd_pkg::WORD_W-1:0]       cal_high_point,
  input  wire logic [htfd_pkg::WORD_W-1:0]       cal_low_point,
  input  wire logic                              calibration_enable,
  output logic                                   v_out,
  output htfd_pkg::htfd_div_t                    div_out,
  output htfd_pkg::htfd_side_t                   side_out
);

  logic [htfd_pkg::WORD_W-1:0]        traw, hraw, dmag, den_mag;
  logic signed [htfd_pkg::TEMP_W-1:0] temp, temp_rel;
  logic                               cal, crc_err, d_neg, den_neg;
  logic [htfd_pkg::NQ_W-1:0]          num_cal, num_unc;

  assign traw = {temp_high, temp_low};
  assign hraw = {hum_high, hum_low};

  assign crc_err = (htfd_pkg::pair_crc(temp_high, temp_low) != temp_check) ||
                   (htfd_pkg::pair_crc(hum_high, hum_low) != hum_check);

  assign temp     = $signed({traw[htfd_pkg::WORD_W-1], traw}) + htfd_pkg::TEMP_OFFSET;
  assign temp_rel = temp - htfd_pkg::TEMP_REF;

  assign cal     = calibration_enable && (cal_high_point != cal_low_point);
  assign d_neg   = hraw < cal_low_point;
  assign dmag    = d_neg ? (cal_low_point - hraw) : (hraw - cal_low_point);
  assign den_neg = cal_high_point < cal_low_point;
  assign den_mag = den_neg ? (cal_low_point - cal_high_point)
                           : (cal_high_point - cal_low_point);

  // x * 15360 = x * 16384 - x * 1024; x * 25600 = x * (16384 + 8192 + 1024)
  assign num_cal = (htfd_pkg::NQ_W'(dmag) << 14) - (htfd_pkg::NQ_W'(dmag) << 10);
  assign num_unc = (htfd_pkg::NQ_W'(hraw) << 14) + (htfd_pkg::NQ_W'(hraw) << 13) +
                   (htfd_pkg::NQ_W'(hraw) << 10);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_out.rem    <= '0;
      div_out.nq     <= cal ? num_cal : num_unc;
      div_out.den    <= cal ? den_mag : htfd_pkg::RAW_FULL;
      side_out.crc_err <= crc_err;
      side_out.temp    <= temp;
      side_out.tterm   <= temp_rel[htfd_pkg::TEMP_W-1:2];
      side_out.cal     <= cal;
      side_out.neg     <= cal && (d_neg ^ den_neg);
    end
  end

endmodule
`default_nettype wire

>>> rtl/htfd_div_stage.sv
`default_nettype none
module htfd_div_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 v_in,
  input  wire htfd_pkg::htfd_div_t  div_in,
  input  wire htfd_pkg::htfd_side_t side_in,
  output logic                      v_out,
  output htfd_pkg::htfd_div_t       div_out,
  output htfd_pkg::htfd_side_t      side_out
);

  logic [htfd_pkg::WORD_W:0] trial, diff;
  logic                      ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {div_in.rem, div_in.nq[htfd_pkg::NQ_W-1]};
  assign ge    = trial >= {1'b0, div_in.den};
  assign diff  = ge ? (trial - {1'b0, div_in.den}) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_out.rem <= diff[htfd_pkg::WORD_W-1:0];
      div_out.nq  <= {div_in.nq[htfd_pkg::NQ_W-2:0], ge};
      div_out.den <= div_in.den;
      side_out    <= side_in;
    end
  end

endmodule
`default_nettype wire

>>> rtl/htfd_back.sv
`default_nettype none
module htfd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          v_in,
  input  wire logic [htfd_pkg::NQ_W-1:0]     quot,
  input  wire htfd_pkg::htfd_side_t          side_in,
  output logic                               v_out,
  output logic                               status,
  output logic signed [htfd_pkg::TEMP_W-1:0] temperature_q8,
  output logic [htfd_pkg::HUM_W-1:0]         humidity_q8,
  output logic                               cal_applied
);

  logic signed [htfd_pkg::SUM_W-1:0] qmag, qs, sum;
  logic [htfd_pkg::HUM_W-1:0]        hum;

  assign qmag = $signed({2'b00, quot});
  assign qs   = side_in.neg ? -qmag : qmag;
  assign sum  = qs + (side_in.cal ? htfd_pkg::HUM_BASE : '0) +
                htfd_pkg::SUM_W'(side_in.tterm);

  always_comb begin
    if (sum > htfd_pkg::HUM_FULL) begin
      hum = htfd_pkg::HUM_FULL[htfd_pkg::HUM_W-1:0];
    end else if (sum < 0) begin
      hum = '0;
    end else begin
      hum = sum[htfd_pkg::HUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status         <= side_in.crc_err;
      temperature_q8 <= side_in.crc_err ? '0 : side_in.temp;
      humidity_q8    <= side_in.crc_err ? '0 : hum;
      cal_applied    <= side_in.cal && !side_in.crc_err;
    end
  end

endmodule
`default_nettype wire

>>> rtl/htfd_checker.sv
`default_nettype none
module htfd_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                frame_stall,
  input wire logic                                result_valid,
  input wire logic                                result_stall,
  input wire logic                                status,
  input wire logic signed [htfd_pkg::TEMP_W-1:0]  temperature_q8,
  input wire logic [htfd_pkg::HUM_W-1:0]          humidity_q8,
  input wire logic                                cal_applied
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(humidity_q8) &&
    $stable(temperature_q8) && $stable(status) && $stable(cal_applied))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> temperature_q8 == 0 && humidity_q8 == 0 &&
    !cal_applied)
    else $error("CRC error beat carries readings");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> humidity_q8 <= 15'd25600)
    else $error("humidity above full scale");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !frame_stall)
    else $error("input stalled with output empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result beat straight after reset");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
  .clk            (clk),
  .rst            (rst),
  .frame_stall    (frame_stall),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .status         (status),
  .temperature_q8 (temperature_q8),
  .humidity_q8    (humidity_q8),
  .cal_applied    (cal_applied)
);
`default_nettype wire

>>> tb/humidity_temp_frame_decoder_core_tb.sv
`default_nettype none
module humidity_temp_frame_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 33;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 750;
  // Index past the register list
  localparam logic [htfd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One decoded frame as the block reports it
  typedef struct packed {
    logic                               status;
    logic signed [htfd_pkg::TEMP_W-1:0] temperature;
    logic [htfd_pkg::HUM_W-1:0]         humidity;
    logic                               used_cal;
  } reading_t;

  // Directed row: frame bytes, optional typed-in expectation
  typedef struct {
    logic [7:0] th, tl, tc, hh, hl, hc;
    bit         typed;
    reading_t   want;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [htfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [htfd_pkg::WORD_W-1:0] cfg_data = '0;
  logic frame_valid = 1'b0;
  logic frame_stall;
  logic [7:0] temp_high = '0, temp_low = '0, temp_check = '0;
  logic [7:0] hum_high = '0, hum_low = '0, hum_check = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic status;
  logic signed [htfd_pkg::TEMP_W-1:0] temperature_q8;
  logic [htfd_pkg::HUM_W-1:0] humidity_q8;
  logic cal_applied;

  humidity_temp_frame_decoder_core i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Own copy of the calibration registers
  logic [15:0] cal_high_q, cal_low_q;
  logic        cal_en_q;
  reading_t pending_readings[$];
  int  fail_count = 0;
  int  send_idle_pct = 0, recv_idle_pct = 0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  function automatic logic [7:0] crc8_pair(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'hFF;
    for (int i = 0; i < 16; i++) begin
      if (i == 0) acc = acc ^ a;
      if (i == 8) acc = acc ^ b;
      acc = acc[7] ? ((acc << 1) ^ 8'h31) : (acc << 1);
    end
    return acc;
  endfunction

  function automatic reading_t decode_frame(logic [7:0] th, tl, tc, hh, hl, hc);
    reading_t r;
    longint temp, hum, num, den, t;
    bit cal;
    r = '0;
    if (crc8_pair(th, tl) != tc || crc8_pair(hh, hl) != hc) begin
      r.status = 1'b1;
      return r;
    end
    temp = longint'($signed({th, tl})) + 10240;
    cal = cal_en_q && (cal_high_q != cal_low_q);
    if (cal) begin
      num = (longint'({hh, hl}) - longint'(cal_low_q)) * 15360;
      den = longint'(cal_high_q) - longint'(cal_low_q);
      hum = num / den + 7680;   // SV division truncates toward zero
    end else begin
      hum = (longint'({hh, hl}) * 25600) / 65535;
    end
    t = temp - 6400;
    hum += t >>> 2;
    if (hum > 25600) hum = 25600;
    if (hum < 0) hum = 0;
    r.temperature = temp[htfd_pkg::TEMP_W-1:0];
    r.humidity = hum[htfd_pkg::HUM_W-1:0];
    r.used_cal = cal;
    return r;
  endfunction

  // Write one register while idle; mirror it in the predictor
  task automatic write_reg(logic [htfd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      htfd_pkg::REG_CAL_HIGH:   cal_high_q = value;
      htfd_pkg::REG_CAL_LOW:    cal_low_q = value;
      htfd_pkg::REG_CAL_ENABLE: cal_en_q = value[0];
      default: ;
    endcase
  endtask

  task automatic set_calibration(logic [15:0] hi, logic [15:0] lo, logic en);
    write_reg(htfd_pkg::REG_CAL_HIGH, hi);
    write_reg(htfd_pkg::REG_CAL_LOW, lo);
    write_reg(htfd_pkg::REG_CAL_ENABLE, {15'd0, en});
  endtask

  // Offer one frame beat and hold it until accepted. Call at a falling edge;
  // returns at a falling edge with valid still high, so beats can follow
  // back to back. The caller drops valid when the run ends.
  task automatic send_frame(logic [7:0] th, tl, tc, hh, hl, hc);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      frame_valid <= 1'b0;
      @(negedge clk);
    end
    frame_valid <= 1'b1;
    temp_high <= th; temp_low <= tl; temp_check <= tc;
    hum_high <= hh; hum_low <= hl; hum_check <= hc;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    pending_readings.push_back(decode_frame(th, tl, tc, hh, hl, hc));
    @(negedge clk);
  endtask

  // Drop valid, then wait until every pending result has come out
  task automatic drain_results();
    frame_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Random frame: mostly good CRCs, some broken ones
  task automatic random_frame();
    logic [7:0] th, tl, tc, hh, hl, hc;
    th = 8'($urandom); tl = 8'($urandom); hh = 8'($urandom); hl = 8'($urandom);
    tc = crc8_pair(th, tl);
    hc = crc8_pair(hh, hl);
    if ($urandom_range(9) == 0) tc = 8'($urandom);
    if ($urandom_range(9) == 0) hc ^= 8'(1 << $urandom_range(7));
    send_frame(th, tl, tc, hh, hl, hc);
  endtask

  // Receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_off) begin
      result_stall <= 1'b1;
    end else begin
      result_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check every result beat against the oldest pending reading
  always @(posedge clk) begin
    reading_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_readings.size() == 0) begin
        $error("result beat with no frame pending");
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d got %0d", want.status, status);
          fail_count++;
        end
        if (temperature_q8 !== want.temperature) begin
          $error("temperature_q8: expected %0d got %0d", want.temperature, temperature_q8);
          fail_count++;
        end
        if (humidity_q8 !== want.humidity) begin
          $error("humidity_q8: expected %0d got %0d", want.humidity, humidity_q8);
          fail_count++;
        end
        if (cal_applied !== want.used_cal) begin
          $error("cal_applied: expected %0d got %0d", want.used_cal, cal_applied);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side
  always @(posedge clk) begin
    if ((frame_valid && !frame_stall) || (result_valid && !result_stall) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  frame_row_t directed[$];

  function automatic frame_row_t good_row(logic [7:0] th, tl, hh, hl);
    frame_row_t r;
    r = '{th, tl, crc8_pair(th, tl), hh, hl, crc8_pair(hh, hl), 1'b0, '0};
    return r;
  endfunction

  initial begin
    frame_row_t r;
    reading_t typed_err;
    cal_high_q = '0; cal_low_q = '0; cal_en_q = 1'b0;
    typed_err = '{1'b1, '0, '0, 1'b0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: extremes, CRC errors on each pair, zero frame
    directed.push_back(good_row(8'h00, 8'h00, 8'h00, 8'h00));
    directed.push_back(good_row(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    directed.push_back(good_row(8'h7F, 8'hFF, 8'h80, 8'h00));
    directed.push_back(good_row(8'h80, 8'h00, 8'h7F, 8'hFF));
    directed.push_back(good_row(8'hAA, 8'h55, 8'h55, 8'hAA));
    directed.push_back(good_row(8'h0F, 8'h00, 8'h66, 8'h66));
    r = good_row(8'h12, 8'h34, 8'h56, 8'h78);
    r.tc = ~r.tc; r.typed = 1'b1; r.want = typed_err;
    directed.push_back(r);
    r = good_row(8'h12, 8'h34, 8'h56, 8'h78);
    r.hc ^= 8'h01; r.typed = 1'b1; r.want = typed_err;
    directed.push_back(r);
    r = good_row(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    r.tc ^= 8'h80; r.hc ^= 8'h80; r.typed = 1'b1; r.want = typed_err;
    directed.push_back(r);

    // Walk the table under each calibration setting
    for (int pass = 0; pass < 5; pass++) begin
      case (pass)
        0: ;                                                  // after reset
        1: set_calibration(16'd50000, 16'd20000, 1'b1);       // normal
        2: set_calibration(16'd1234, 16'd1234, 1'b1);         // equal points
        3: set_calibration(16'd0, 16'hFFFF, 1'b1);            // inverted span
        4: set_calibration(16'hFFFF, 16'd0, 1'b0);            // disabled
        default: ;
      endcase
      foreach (directed[i]) begin
        r = directed[i];
        send_frame(r.th, r.tl, r.tc, r.hh, r.hl, r.hc);
        if (r.typed && pending_readings[$] != r.want) begin
          $error("typed row %0d disagrees with predictor", i);
          fail_count++;
        end
      end
      drain_results();
    end
    // Out-of-range index: must be ignored
    write_reg(REG_UNUSED, 16'hFFFF);

    // Random part in three idling phases, new calibration each phase
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 37 : 0;
      set_calibration(16'($urandom), 16'($urandom_range(1) ? $urandom : 16'd0),
                      1'($urandom_range(3) != 0));
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) random_frame();
      drain_results();
    end

    // Hold the receiver off long enough to fill the pipeline
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        @(negedge clk);
        for (int n = 0; n < 60; n++) random_frame();
        frame_valid <= 1'b0;
      end
    join
    drain_results();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
